>>> rtl/eebx_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// eebx_pkg: shared definitions for the Bezout coefficient block
// Widths of the operands, the coefficient datapath and the sequencer states.
// ----------------------------------------------------------------------------
package eebx_pkg;

  // Operand width of value_a and value_b.
  localparam int unsigned OperandWidth = 31;
  // Coefficient datapath width; coefficients wrap modulo 2^DataWidth.
  localparam int unsigned DataWidth    = 32;
  // Width of the output coefficient.
  localparam int unsigned OutWidth     = 32;
  // Shift counter width: the divisor moves left by at most OperandWidth-1 places.
  localparam int unsigned CntWidth     = $clog2(OperandWidth);

  typedef logic [OperandWidth-1:0] operand_t;
  typedef logic [DataWidth-1:0]    coef_t;
  typedef logic [CntWidth-1:0]     cnt_t;

  // Sequencer states, one-hot.
  typedef enum logic [4:0] {
    StIdle   = 5'b00001,
    StAlign  = 5'b00010,
    StSub    = 5'b00100,
    StUpdate = 5'b01000,
    StFinish = 5'b10000
  } state_e;

endpackage
`default_nettype wire

>>> rtl/extended_euclid_bezout_x_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// extended_euclid_bezout_x_top: Bezout coefficient of the first operand
// Runs the extended Euclidean algorithm on (value_a, value_b) with a shared
// shift-subtract divider and returns x such that a*x + b*y = gcd(a, b).
// ----------------------------------------------------------------------------
//
//   Channel | Handshake                  | Payload
//   --------+----------------------------+------------------------------------
//   input   | in_valid_i  / in_ready_o   | value_a_i[30:0], value_b_i[30:0]
//   output  | out_valid_o / out_ready_i  | coeff_x_o[31:0], signed
//
// Sequence: each Euclid step with quotient q runs alignment passes that double
// the divisor while it still fits under the remainder, then shift-subtract
// passes that each yield one quotient bit, then an update; after the last
// step the result moves from the finish state into the output register. A
// zero second operand goes from idle straight to the finish state.
// Reset clears the sequencer and the output valid flag; no clearing pass.
// Stalls: the result sits in its own output register, so a stalled output
// does not hold the next request; only a second result waits in the finish
// state until the output register frees up.
// ----------------------------------------------------------------------------
module extended_euclid_bezout_x_top (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic [eebx_pkg::OperandWidth-1:0] value_a_i,
  input  wire logic [eebx_pkg::OperandWidth-1:0] value_b_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic signed [eebx_pkg::OutWidth-1:0] coeff_x_o
);
  import eebx_pkg::*;

  state_e   state_q, state_d;
  // Running remainder (dividend) and the shifted divisor.
  operand_t rem_q, rem_d;
  operand_t div_q, div_d;
  // Unshifted divisor of the current step; it becomes the next dividend.
  operand_t base_q, base_d;
  cnt_t     cnt_q, cnt_d;
  // Quotient times the newer coefficient, built one quotient bit at a time.
  coef_t    acc_q, acc_d;
  coef_t    prev_q, prev_d;
  coef_t    curr_q, curr_d;
  coef_t    out_q, out_d;
  logic     out_valid_q, out_valid_d;

  logic                  in_fire;
  logic                  out_free;
  logic [OperandWidth:0] div_dbl;
  logic                  can_shift;
  logic                  q_bit;
  operand_t              rem_sub;

  assign in_fire  = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;

  // The shared unit: one compare on the divisor doubled (alignment), and one
  // compare-subtract on the remainder (quotient bit).
  assign div_dbl   = {div_q, 1'b0};
  assign can_shift = (div_dbl <= {1'b0, rem_q});
  assign q_bit     = (rem_q >= div_q);
  assign rem_sub   = rem_q - div_q;

  always_comb begin
    state_d     = state_q;
    rem_d       = rem_q;
    div_d       = div_q;
    base_d      = base_q;
    cnt_d       = cnt_q;
    acc_d       = acc_q;
    prev_d      = prev_q;
    curr_d      = curr_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      StIdle: begin
        if (in_fire) begin
          rem_d  = value_a_i;
          div_d  = value_b_i;
          base_d = value_b_i;
          cnt_d  = '0;
          acc_d  = '0;
          prev_d = coef_t'(1);
          curr_d = '0;
          // A zero second operand gives coefficient one straight away.
          if (value_b_i == '0) begin
            state_d = StFinish;
          end else begin
            state_d = StAlign;
          end
        end
      end
      StAlign: begin
        if (can_shift) begin
          div_d = div_dbl[OperandWidth-1:0];
          cnt_d = cnt_q + cnt_t'(1);
        end else begin
          state_d = StSub;
        end
      end
      StSub: begin
        if (q_bit) begin
          rem_d = rem_sub;
        end
        acc_d = {acc_q[DataWidth-2:0], 1'b0} + (q_bit ? curr_q : '0);
        if (cnt_q == '0) begin
          state_d = StUpdate;
        end else begin
          div_d = {1'b0, div_q[OperandWidth-1:1]};
          cnt_d = cnt_q - cnt_t'(1);
        end
      end
      StUpdate: begin
        prev_d = curr_q;
        curr_d = prev_q - acc_q;
        if (rem_q == '0) begin
          state_d = StFinish;
        end else begin
          // New dividend is the old divisor, new divisor the remainder.
          rem_d   = base_q;
          div_d   = rem_q;
          base_d  = rem_q;
          cnt_d   = '0;
          acc_d   = '0;
          state_d = StAlign;
        end
      end
      StFinish: begin
        if (out_free) begin
          out_d       = prev_q;
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    div_q  <= div_d;
    base_q <= base_d;
    cnt_q  <= cnt_d;
    acc_q  <= acc_d;
    prev_q <= prev_d;
    curr_q <= curr_d;
    out_q  <= out_d;
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;
  assign coeff_x_o   = signed'(out_q[OutWidth-1:0]);

endmodule
`default_nettype wire

>>> rtl/eebx_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// eebx_checker: port-level checks for the Bezout coefficient block
// Watches the top level's handshakes over time.
// ----------------------------------------------------------------------------
module eebx_checker (
  input wire logic                                clk_i,
  input wire logic                                rst_ni,
  input wire logic                                in_valid_i,
  input wire logic                                in_ready_o,
  input wire logic [eebx_pkg::OperandWidth-1:0]   value_a_i,
  input wire logic [eebx_pkg::OperandWidth-1:0]   value_b_i,
  input wire logic                                out_valid_o,
  input wire logic                                out_ready_i,
  input wire logic signed [eebx_pkg::OutWidth-1:0] coeff_x_o
);
  import eebx_pkg::*;

  logic in_fire;
  assign in_fire = in_valid_i && in_ready_o;

  // A stalled result keeps its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(coeff_x_o))
    else $error("result changed or dropped while stalled");

  // The block is busy in the cycle after it takes a request.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_ready_o)
    else $error("ready after accepting a request");

  // No result can appear in the cycle right after a request is taken.
  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !$rose(out_valid_o))
    else $error("result appeared too early");

  // Reset leaves no result pending once it has been seen at a clock edge.
  a_reset_clear: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("result valid after reset");

endmodule

bind extended_euclid_bezout_x_top eebx_checker u_eebx_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .value_a_i   (value_a_i),
  .value_b_i   (value_b_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .coeff_x_o   (coeff_x_o)
);
`default_nettype wire
